// ----- design/afs_pkg.sv -----
`default_nettype none
package afs_pkg;

    localparam int MAX_INSERT_DEF = 1023;
    localparam int COUNT_BITS_DEF = 32;
    localparam int N_CAT          = 11;
    localparam int CAT_DEPTH      = 22;
    localparam int CAT_AW         = 5;
    localparam int MAPQ_DEPTH     = 256;
    localparam int BIN_BITS       = 17;
    localparam int IDX_BITS       = 11;
    localparam int Q_DEPTH        = 4;
    localparam int OUT_DEPTH      = 4;
    localparam logic [7:0] HQ_RESET = 8'd5;

    localparam int CAT_READS    = 0;
    localparam int CAT_MAPPED   = 1;
    localparam int CAT_PAIRED   = 2;
    localparam int CAT_PAIRMAP  = 3;
    localparam int CAT_PROPER   = 4;
    localparam int CAT_SINGLE   = 5;
    localparam int CAT_READ1    = 6;
    localparam int CAT_READ2    = 7;
    localparam int CAT_DUP      = 8;
    localparam int CAT_DIFFCHR  = 9;
    localparam int CAT_DIFFHIGH = 10;

    localparam logic CMD_ACCOUNT = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [1:0] BANK_CAT   = 2'd0;
    localparam logic [1:0] BANK_INS   = 2'd1;
    localparam logic [1:0] BANK_MQF   = 2'd2;
    localparam logic [1:0] BANK_MQO   = 2'd3;

    typedef struct packed {
        logic                cmd;
        logic                qc;
        logic [N_CAT-1:0]    cat_mask;
        logic                ins_en;
        logic [BIN_BITS-1:0] ins_bin;
        logic                mqf_en;
        logic                mqo_en;
        logic [7:0]          qual;
        logic [1:0]          bank;
        logic [IDX_BITS-1:0] index;
    } afs_item_t;

endpackage
`default_nettype wire

// ----- design/afs_queue.sv -----
`default_nettype none
module afs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data,
    output logic [$clog2(DEPTH):0] level
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign level     = cnt_reg;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end
endmodule
`default_nettype wire

// ----- design/afs_front.sv -----
`default_nettype none
module afs_front #(
    parameter int MAX_INSERT = afs_pkg::MAX_INSERT_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [135:0]      s_tdata,
    input  wire logic              s_tuser,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [7:0]        cfg_data,
    output logic                   q_push,
    input  wire logic              q_ready,
    output afs_pkg::afs_item_t     q_item
);
    import afs_pkg::*;

    logic [7:0]  hq_min_reg;
    logic [15:0] flag;
    logic [31:0] isz, tid, mtid;
    logic [7:0]  qual;
    logic        paired, unmap, munmap, both_mapped, diff_chr;
    logic [32:0] mag;

    assign flag = s_tdata[15:0];
    assign isz  = s_tdata[47:16];
    assign tid  = s_tdata[79:48];
    assign mtid = s_tdata[111:80];
    assign qual = s_tdata[119:112];

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign q_push    = s_tvalid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hq_min_reg <= HQ_RESET;
        end else if (cfg_valid) begin
            hq_min_reg <= cfg_data;
        end
    end

    assign paired      = flag[0];
    assign unmap       = flag[2];
    assign munmap      = flag[3];
    assign both_mapped = paired && !unmap && !munmap;
    assign diff_chr    = (mtid != tid);
    assign mag = isz[31] ? (33'h1_0000_0000 - {1'b0, isz}) : {1'b0, isz};

    always_comb begin
        q_item          = '0;
        q_item.cmd      = s_tuser;
        q_item.qc       = flag[9];
        q_item.qual     = qual;
        q_item.bank     = s_tdata[121:120];
        q_item.index    = s_tdata[132:122];
        q_item.cat_mask[CAT_READS]    = 1'b1;
        q_item.cat_mask[CAT_PAIRED]   = paired;
        q_item.cat_mask[CAT_PROPER]   = paired && flag[1];
        q_item.cat_mask[CAT_READ1]    = paired && flag[6];
        q_item.cat_mask[CAT_READ2]    = paired && flag[7];
        q_item.cat_mask[CAT_SINGLE]   = paired && munmap && !unmap;
        q_item.cat_mask[CAT_PAIRMAP]  = both_mapped;
        q_item.cat_mask[CAT_DIFFCHR]  = both_mapped && diff_chr;
        q_item.cat_mask[CAT_DIFFHIGH] = both_mapped && diff_chr && (qual >= hq_min_reg);
        q_item.cat_mask[CAT_MAPPED]   = !unmap;
        q_item.cat_mask[CAT_DUP]      = flag[10];
        q_item.ins_en = both_mapped && (isz != '0);
        if (mag > 33'(MAX_INSERT)) begin
            q_item.ins_bin = BIN_BITS'(MAX_INSERT + 1);
        end else begin
            q_item.ins_bin = BIN_BITS'(mag);
        end
        q_item.mqf_en = !unmap && flag[6];
        q_item.mqo_en = !unmap && !flag[6];
    end
endmodule
`default_nettype wire

// ----- design/afs_back.sv -----
`default_nettype none
module afs_back #(
    parameter int MAX_INSERT = afs_pkg::MAX_INSERT_DEF,
    parameter int COUNT_BITS = afs_pkg::COUNT_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire afs_pkg::afs_item_t q_item,
    output logic                    o_push,
    output logic [32:0]             o_data,
    input  wire logic [$clog2(afs_pkg::OUT_DEPTH):0] o_level
);
    import afs_pkg::*;

    localparam int INS_DEPTH = MAX_INSERT + 2;
    localparam int INS_AW    = $clog2(INS_DEPTH);
    localparam int CLR_DEPTH = (INS_DEPTH > MAPQ_DEPTH) ? INS_DEPTH : MAPQ_DEPTH;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int LVL_W     = $clog2(OUT_DEPTH) + 1;

    logic [COUNT_BITS-1:0] cat_reg [CAT_DEPTH];
    logic [COUNT_BITS-1:0] ins_mem [INS_DEPTH];
    logic [COUNT_BITS-1:0] mqf_mem [MAPQ_DEPTH];
    logic [COUNT_BITS-1:0] mqo_mem [MAPQ_DEPTH];

    logic [COUNT_BITS-1:0] ins_rd_reg, mqf_rd_reg, mqo_rd_reg;

    logic              clr_active_reg;
    logic [CLR_AW-1:0] clr_cnt_reg;

    // Stage 0 address and read-side decode.
    logic [INS_AW-1:0]     ins_addr;
    logic [7:0]            mq_addr;
    logic                  bad0;
    logic [COUNT_BITS-1:0] cat_val0;

    // Stage 1 holds the item while the memory read data arrives.
    logic                  s1_valid_reg;
    afs_item_t             s1_item_reg;
    logic [INS_AW-1:0]     s1_ins_addr_reg;
    logic [7:0]            s1_mq_addr_reg;
    logic                  s1_bad_reg;
    logic [COUNT_BITS-1:0] s1_cat_val_reg;

    // The last write to each memory is forwarded to a read of the same entry
    // issued in the same cycle.
    logic                  ins_lw_en_reg, mqf_lw_en_reg, mqo_lw_en_reg;
    logic [INS_AW-1:0]     ins_lw_addr_reg;
    logic [7:0]            mqf_lw_addr_reg, mqo_lw_addr_reg;
    logic [COUNT_BITS-1:0] ins_lw_data_reg, mqf_lw_data_reg, mqo_lw_data_reg;

    logic [COUNT_BITS-1:0] ins_cur, mqf_cur, mqo_cur, ins_new, mqf_new, mqo_new;
    logic                  ins_we, mqf_we, mqo_we;
    logic [COUNT_BITS-1:0] rd_val;
    logic                  credit_ok;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    assign credit_ok = (LVL_W'(o_level) + LVL_W'(s1_valid_reg && s1_item_reg.cmd)
                        < LVL_W'(OUT_DEPTH));
    assign q_pop = q_valid && !clr_active_reg && (q_item.cmd == CMD_ACCOUNT || credit_ok);

    always_comb begin
        if (q_item.cmd == CMD_READ) begin
            ins_addr = INS_AW'(q_item.index);
            mq_addr  = q_item.index[7:0];
        end else begin
            ins_addr = INS_AW'(q_item.ins_bin);
            mq_addr  = q_item.qual;
        end
        case (q_item.bank)
            BANK_CAT: bad0 = (32'(q_item.index) >= 32'(CAT_DEPTH));
            BANK_INS: bad0 = (32'(q_item.index) >= 32'(INS_DEPTH));
            default:  bad0 = (32'(q_item.index) >= 32'(MAPQ_DEPTH));
        endcase
        if (32'(q_item.index) < 32'(CAT_DEPTH)) begin
            cat_val0 = cat_reg[q_item.index[CAT_AW-1:0]];
        end else begin
            cat_val0 = '0;
        end
    end

    always_ff @(posedge aclk) begin
        ins_rd_reg <= ins_mem[ins_addr];
        mqf_rd_reg <= mqf_mem[mq_addr];
        mqo_rd_reg <= mqo_mem[mq_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CAT_DEPTH; i++) begin
                cat_reg[i] <= '0;
            end
        end else if (q_pop && q_item.cmd == CMD_ACCOUNT) begin
            for (int c = 0; c < N_CAT; c++) begin
                if (q_item.cat_mask[c]) begin
                    cat_reg[c*2 + int'(q_item.qc)] <= sat_inc(cat_reg[c*2 + int'(q_item.qc)]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            ins_lw_en_reg  <= 1'b0;
            mqf_lw_en_reg  <= 1'b0;
            mqo_lw_en_reg  <= 1'b0;
        end else begin
            s1_valid_reg  <= q_pop;
            ins_lw_en_reg <= ins_we;
            mqf_lw_en_reg <= mqf_we;
            mqo_lw_en_reg <= mqo_we;
            if (clr_active_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        s1_item_reg     <= q_item;
        s1_ins_addr_reg <= ins_addr;
        s1_mq_addr_reg  <= mq_addr;
        s1_bad_reg      <= bad0;
        s1_cat_val_reg  <= cat_val0;
        ins_lw_addr_reg <= s1_ins_addr_reg;
        mqf_lw_addr_reg <= s1_mq_addr_reg;
        mqo_lw_addr_reg <= s1_mq_addr_reg;
        ins_lw_data_reg <= ins_new;
        mqf_lw_data_reg <= mqf_new;
        mqo_lw_data_reg <= mqo_new;
    end

    always_comb begin
        ins_cur = (ins_lw_en_reg && ins_lw_addr_reg == s1_ins_addr_reg)
                  ? ins_lw_data_reg : ins_rd_reg;
        mqf_cur = (mqf_lw_en_reg && mqf_lw_addr_reg == s1_mq_addr_reg)
                  ? mqf_lw_data_reg : mqf_rd_reg;
        mqo_cur = (mqo_lw_en_reg && mqo_lw_addr_reg == s1_mq_addr_reg)
                  ? mqo_lw_data_reg : mqo_rd_reg;
        ins_new = sat_inc(ins_cur);
        mqf_new = sat_inc(mqf_cur);
        mqo_new = sat_inc(mqo_cur);
        ins_we  = s1_valid_reg && s1_item_reg.cmd == CMD_ACCOUNT && s1_item_reg.ins_en;
        mqf_we  = s1_valid_reg && s1_item_reg.cmd == CMD_ACCOUNT && s1_item_reg.mqf_en;
        mqo_we  = s1_valid_reg && s1_item_reg.cmd == CMD_ACCOUNT && s1_item_reg.mqo_en;
    end

    always_ff @(posedge aclk) begin
        if (clr_active_reg) begin
            if (32'(clr_cnt_reg) < 32'(INS_DEPTH)) begin
                ins_mem[INS_AW'(clr_cnt_reg)] <= '0;
            end
            if (32'(clr_cnt_reg) < 32'(MAPQ_DEPTH)) begin
                mqf_mem[clr_cnt_reg[7:0]] <= '0;
                mqo_mem[clr_cnt_reg[7:0]] <= '0;
            end
        end else begin
            if (ins_we) begin
                ins_mem[s1_ins_addr_reg] <= ins_new;
            end
            if (mqf_we) begin
                mqf_mem[s1_mq_addr_reg] <= mqf_new;
            end
            if (mqo_we) begin
                mqo_mem[s1_mq_addr_reg] <= mqo_new;
            end
        end
    end

    always_comb begin
        case (s1_item_reg.bank)
            BANK_CAT: rd_val = s1_cat_val_reg;
            BANK_INS: rd_val = ins_cur;
            BANK_MQF: rd_val = mqf_cur;
            BANK_MQO: rd_val = mqo_cur;
            default:  rd_val = '0;
        endcase
        if (s1_bad_reg) begin
            rd_val = '0;
        end
        o_push = s1_valid_reg && s1_item_reg.cmd == CMD_READ;
        if (rd_val > COUNT_BITS'(32'hFFFF_FFFF)) begin
            o_data = {s1_bad_reg, 32'hFFFF_FFFF};
        end else begin
            o_data = {s1_bad_reg, 32'(rd_val)};
        end
    end
endmodule
`default_nettype wire

// ----- design/alignment_flag_statistics_core.sv -----
`default_nettype none
// Throughput: one beat per cycle for accounting and read beats alike, except during the
// clearing pass and, for read beats, while the output queue has no free entry. A read beat
// passes the command queue, the memory read and the output queue before m_tvalid rises.
// Histograms are read-modify-write through a registered read port with last-write forwarding.
// Reset: synchronous, active low; afterwards a clearing pass over max(MAX_INSERT+2, 256)
// entries zeroes the histogram memories, during which input beats queue but are not processed.
module alignment_flag_statistics_core #(
    parameter int MAX_INSERT = afs_pkg::MAX_INSERT_DEF,
    parameter int COUNT_BITS = afs_pkg::COUNT_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // flag_bits, insert_size, ref_id, mate_ref_id, map_quality, read_bank, read_index
    input  wire logic [135:0] s_tdata,
    // command
    input  wire logic         s_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_data,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // count_value
    output logic [31:0]       m_tdata,
    // bad_index
    output logic              m_tuser
);
    import afs_pkg::*;

    logic      fq_push, fq_ready, bq_valid, bq_pop, o_push;
    afs_item_t fq_item, bq_item;
    logic [32:0] o_data, m_word;
    logic [$clog2(OUT_DEPTH):0] o_level;
    logic [$clog2(Q_DEPTH):0]   q_level;

    afs_front #(.MAX_INSERT(MAX_INSERT)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .cfg_valid, .cfg_ready, .cfg_data,
        .q_push(fq_push), .q_ready(fq_ready), .q_item(fq_item)
    );

    afs_queue #(.WIDTH($bits(afs_item_t)), .DEPTH(Q_DEPTH)) u_cmd_q (
        .aclk, .aresetn,
        .in_valid(fq_push), .in_ready(fq_ready), .in_data(fq_item),
        .out_valid(bq_valid), .out_ready(bq_pop), .out_data(bq_item),
        .level(q_level)
    );

    afs_back #(.MAX_INSERT(MAX_INSERT), .COUNT_BITS(COUNT_BITS)) u_back (
        .aclk, .aresetn,
        .q_valid(bq_valid), .q_pop(bq_pop), .q_item(bq_item),
        .o_push, .o_data, .o_level
    );

    afs_queue #(.WIDTH(33), .DEPTH(OUT_DEPTH)) u_out_q (
        .aclk, .aresetn,
        .in_valid(o_push), .in_ready(), .in_data(o_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_word),
        .level(o_level)
    );

    assign m_tdata = m_word[31:0];
    assign m_tuser = m_word[32] & (q_level == q_level);
endmodule
`default_nettype wire

// ----- tb/alignment_flag_statistics_core_test.sv -----
`default_nettype none
module alignment_flag_statistics_core_test;
    import afs_pkg::*;

    localparam int MAXI = MAX_INSERT_DEF;
    localparam int INS_DEPTH = MAXI + 2;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] count_value;
        logic        bad_index;
    } count_reply_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic         m_tuser;

    alignment_flag_statistics_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 aclk = ~aclk;

    // Mirror of the block's stores; counters never pass 2^32-1 in this run.
    logic [31:0] cat_counts [CAT_DEPTH];
    logic [31:0] insert_bins [INS_DEPTH];
    logic [31:0] mapq_first [MAPQ_DEPTH];
    logic [31:0] mapq_other [MAPQ_DEPTH];
    logic [7:0]  hq_min;
    count_reply_t pending_replies [$];

    int  errors = 0;
    int  send_gap_pct = 0;
    int  recv_stall_pct = 0;
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;

    function automatic void bump_count(ref logic [31:0] cnt);
        if (cnt != 32'hFFFF_FFFF) cnt = cnt + 32'd1;
    endfunction

    function automatic void bump_cat(int cat, logic qc);
        bump_count(cat_counts[cat * 2 + int'(qc)]);
    endfunction

    function automatic void clear_stores();
        foreach (cat_counts[i]) cat_counts[i] = '0;
        foreach (insert_bins[i]) insert_bins[i] = '0;
        foreach (mapq_first[i]) mapq_first[i] = '0;
        foreach (mapq_other[i]) mapq_other[i] = '0;
        hq_min = HQ_RESET;
    endfunction

    function automatic void account_record(logic [15:0] flag, logic [31:0] isz,
                                           logic [31:0] tid, logic [31:0] mtid,
                                           logic [7:0] qual);
        logic qc;
        logic unmap;
        logic munmap;
        logic [31:0] mag;
        qc = flag[9];
        unmap = flag[2];
        munmap = flag[3];
        bump_cat(CAT_READS, qc);
        if (flag[0]) begin
            bump_cat(CAT_PAIRED, qc);
            if (flag[1]) bump_cat(CAT_PROPER, qc);
            if (flag[6]) bump_cat(CAT_READ1, qc);
            if (flag[7]) bump_cat(CAT_READ2, qc);
            if (munmap && !unmap) bump_cat(CAT_SINGLE, qc);
            if (!unmap && !munmap) begin
                if (isz != 0) begin
                    mag = isz[31] ? -isz : isz;
                    if (mag > MAXI) bump_count(insert_bins[MAXI + 1]);
                    else bump_count(insert_bins[mag]);
                end
                bump_cat(CAT_PAIRMAP, qc);
                if (mtid != tid) begin
                    bump_cat(CAT_DIFFCHR, qc);
                    if (qual >= hq_min) bump_cat(CAT_DIFFHIGH, qc);
                end
            end
        end
        if (!unmap) begin
            bump_cat(CAT_MAPPED, qc);
            if (flag[6]) bump_count(mapq_first[qual]);
            else bump_count(mapq_other[qual]);
        end
        if (flag[10]) bump_cat(CAT_DUP, qc);
    endfunction

    function automatic count_reply_t look_up(logic [1:0] bank, logic [10:0] idx);
        count_reply_t r;
        r = '0;
        case (bank)
            BANK_CAT: if (idx < CAT_DEPTH) r.count_value = cat_counts[idx];
                      else r.bad_index = 1'b1;
            BANK_INS: if (idx < INS_DEPTH) r.count_value = insert_bins[idx];
                      else r.bad_index = 1'b1;
            BANK_MQF: if (idx < MAPQ_DEPTH) r.count_value = mapq_first[idx];
                      else r.bad_index = 1'b1;
            default:  if (idx < MAPQ_DEPTH) r.count_value = mapq_other[idx];
                      else r.bad_index = 1'b1;
        endcase
        return r;
    endfunction

    task automatic send_beat(logic cmd, logic [15:0] flag, logic [31:0] isz,
                             logic [31:0] tid, logic [31:0] mtid, logic [7:0] qual,
                             logic [1:0] bank, logic [10:0] idx);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= 136'({idx, bank, qual, mtid, tid, isz, flag});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (cmd == CMD_READ) pending_replies.push_back(look_up(bank, idx));
        else account_record(flag, isz, tid, mtid, qual);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic read_count(logic [1:0] bank, logic [10:0] idx);
        send_beat(CMD_READ, 16'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
                  8'($urandom), bank, idx);
    endtask

    task automatic account(logic [15:0] flag, logic [31:0] isz, logic [31:0] tid,
                           logic [31:0] mtid, logic [7:0] qual);
        send_beat(CMD_ACCOUNT, flag, isz, tid, mtid, qual, 2'($urandom), 11'($urandom));
    endtask

    task automatic drain();
        end_burst();
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_hq_min(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        hq_min = value;
    endtask

    // Reads every category counter so accumulated state is compared in full.
    task automatic read_all_categories();
        for (int i = 0; i < CAT_DEPTH; i++) read_count(BANK_CAT, 11'(i));
    endtask

    task automatic test_directed();
        account(16'h0043, 32'd150, 32'd0, 32'd0, 8'd60);
        account(16'h0083, 32'hFFFF_FF6A, 32'd0, 32'd0, 8'd0);
        account(16'h0001, 32'd5000, 32'd1, 32'd2, 8'd255);
        account(16'h0001, 32'h8000_0000, 32'd1, 32'd1, 8'd4);
        account(16'h0001, 32'd1023, 32'd3, 32'd4, 8'd5);
        account(16'h0001, 32'd1024, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'd3);
        account(16'h0209, 32'd0, 32'd0, 32'd0, 8'd7);
        account(16'h0045, 32'd0, 32'd0, 32'd0, 8'd7);
        account(16'h0600, 32'h7FFF_FFFF, 32'd0, 32'd0, 8'd200);
        account(16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd255);
        account(16'hFDFB, 32'd1, 32'd0, 32'd9, 8'd255);
        account(16'h0000, 32'd0, 32'd0, 32'd0, 8'd0);
        read_all_categories();
        read_count(BANK_INS, 11'd0);
        read_count(BANK_INS, 11'd150);
        read_count(BANK_INS, 11'd1);
        read_count(BANK_INS, 11'(MAXI));
        read_count(BANK_INS, 11'(MAXI + 1));
        read_count(BANK_INS, 11'(MAXI + 2));
        read_count(BANK_INS, 11'h7FF);
        read_count(BANK_CAT, 11'(CAT_DEPTH));
        read_count(BANK_MQF, 11'd60);
        read_count(BANK_MQF, 11'd255);
        read_count(BANK_MQO, 11'd255);
        read_count(BANK_MQO, 11'd0);
        read_count(BANK_MQO, 11'd256);
        read_count(BANK_MQF, 11'h400);
        drain();
    endtask

    task automatic random_phase(int beats);
        logic [15:0] flag;
        logic [31:0] isz;
        logic [31:0] tid;
        logic [1:0]  bank;
        for (int n = 0; n < beats; n++) begin
            if ($urandom_range(99) < 30) begin
                bank = 2'($urandom);
                case ($urandom_range(3))
                    0: read_count(bank, 11'($urandom_range(2047)));
                    1: read_count(BANK_CAT, 11'($urandom_range(CAT_DEPTH - 1)));
                    2: read_count(bank, 11'($urandom_range(20)));
                    default: read_count(bank, 11'($urandom_range(INS_DEPTH)));
                endcase
            end else begin
                flag = 16'($urandom);
                if ($urandom_range(99) < 70) flag[3:2] = ($urandom_range(3) == 0) ? flag[3:2] : 2'b00;
                if ($urandom_range(99) < 70) flag[0] = 1'b1;
                case ($urandom_range(4))
                    0: isz = $urandom;
                    1: isz = 32'd0;
                    2: isz = -$urandom_range(1100);
                    default: isz = $urandom_range(1100);
                endcase
                tid = ($urandom_range(1) != 0) ? $urandom_range(3) : $urandom;
                account(flag, isz, tid,
                        ($urandom_range(1) != 0) ? tid : $urandom_range(4) - 1,
                        8'($urandom));
            end
        end
        read_all_categories();
        drain();
    endtask

    initial begin
        clear_stores();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_gap_pct = 6;
        recv_stall_pct = 72;
        write_hq_min(8'd0);
        random_phase(180);
        send_gap_pct = 72;
        recv_stall_pct = 6;
        write_hq_min(8'd255);
        random_phase(180);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        write_hq_min(8'($urandom_range(1, 254)));
        random_phase(180);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // Receiver stalls; also accepts and checks each result beat.
    always @(posedge aclk) begin
        count_reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected result count=%h bad=%b", $time, m_tdata, m_tuser);
                errors <= errors + 1;
            end else begin
                exp_r = pending_replies.pop_front();
                if (m_tdata !== exp_r.count_value || m_tuser !== exp_r.bad_index) begin
                    $display("%0t: mismatch expected count=%h bad=%b actual count=%h bad=%b",
                             $time, exp_r.count_value, exp_r.bad_index, m_tdata, m_tuser);
                    errors <= errors + 1;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end
endmodule
`default_nettype wire
